/* rtl/awns_pkg.sv */
package awns_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_A11 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A12 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A13 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A21 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A22 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A23 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd7;

  typedef struct packed {
    logic       mode;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] in_ch0;
    logic [7:0] in_ch1;
    logic [7:0] in_ch2;
  } awns_in_t;

  typedef struct packed {
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic       inside_res;
  } awns_out_t;

  typedef struct packed {
    logic [31:0] a11;
    logic [31:0] a12;
    logic [31:0] a13;
    logic [31:0] a21;
    logic [31:0] a22;
    logic [31:0] a23;
    logic [8:0]  src_width;
    logic [8:0]  src_height;
  } awns_cfg_t;

  typedef struct packed {
    logic        is_sample;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [23:0] pix;
  } awns_entry_t;

endpackage

/* rtl/awns_cfg_regs.sv */
module awns_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [awns_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  output awns_pkg::awns_cfg_t             cfg_o
);
  import awns_pkg::*;

  awns_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_A11:        cfg_d.a11 = cfg_data_i;
        REG_A12:        cfg_d.a12 = cfg_data_i;
        REG_A13:        cfg_d.a13 = cfg_data_i;
        REG_A21:        cfg_d.a21 = cfg_data_i;
        REG_A22:        cfg_d.a22 = cfg_data_i;
        REG_A23:        cfg_d.a23 = cfg_data_i;
        REG_SRC_WIDTH:  cfg_d.src_width = cfg_data_i[8:0];
        REG_SRC_HEIGHT: cfg_d.src_height = cfg_data_i[8:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a11        <= 32'd65536;
      cfg_q.a12        <= 32'd0;
      cfg_q.a13        <= 32'd0;
      cfg_q.a21        <= 32'd0;
      cfg_q.a22        <= 32'd65536;
      cfg_q.a23        <= 32'd0;
      cfg_q.src_width  <= 9'd256;
      cfg_q.src_height <= 9'd256;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/awns_front.sv */
module awns_front #(
  parameter int IMAGE_DIM = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  awns_pkg::awns_in_t     in_data_i,
  output logic                   q_valid_o,
  output awns_pkg::awns_entry_t  q_entry_o,
  input  logic                   pop_i
);
  import awns_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  awns_entry_t entries_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          accept, keep, push;
  awns_entry_t   entry;

  // loads that fall outside the store are dropped here
  always_comb begin
    entry.is_sample = (in_data_i.mode == MODE_SAMPLE);
    entry.col = in_data_i.col;
    entry.row = in_data_i.row;
    entry.pix = {in_data_i.in_ch2, in_data_i.in_ch1, in_data_i.in_ch0};
    keep = entry.is_sample ||
           ((32'(in_data_i.col) < 32'(IMAGE_DIM)) && (32'(in_data_i.row) < 32'(IMAGE_DIM)));
  end

  assign in_stall_o = (count_q == CW'(QUEUE_DEPTH));
  assign accept = in_valid_i && !in_stall_o;
  assign push = accept && keep;
  assign q_valid_o = (count_q != '0);
  assign q_entry_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= entry;
    end
  end

endmodule

/* rtl/awns_back.sv */
module awns_back #(
  parameter int IMAGE_DIM = 256,
  parameter int CHANNELS = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  awns_pkg::awns_cfg_t    cfg_i,
  input  logic                   q_valid_i,
  input  awns_pkg::awns_entry_t  q_entry_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output awns_pkg::awns_out_t    out_data_o
);
  import awns_pkg::*;

  localparam int AW = $clog2(IMAGE_DIM);
  localparam int CARRIED = (CHANNELS < 3) ? CHANNELS : 3;
  localparam int MEM_W = 8 * CARRIED;
  localparam int DEPTH = 1 << (2 * AW);
  localparam logic signed [42:0] ROUND_HALF = 43'sd32768;

  logic en;

  logic               s1_valid_q;
  awns_entry_t        s1_entry_q;
  logic signed [40:0] p11_q, p12_q, p21_q, p22_q;
  logic signed [40:0] p11_d, p12_d, p21_d, p22_d;

  logic               s2_valid_q;
  awns_entry_t        s2_entry_q;
  logic signed [42:0] sx, sy;
  logic [26:0]        ix_q, iy_q;

  logic               s3_valid_q, s3_sample_q, s3_inside_q;
  logic               inside_d;
  logic [2*AW-1:0]    s3_addr_q, addr_d;
  logic [MEM_W-1:0]   s3_pix_q;

  logic [MEM_W-1:0]   mem [DEPTH];
  logic [MEM_W-1:0]   rdata_q;
  logic               out_valid_q, out_inside_q;
  logic [23:0]        pix_out;

  assign en = !out_valid_q || !out_stall_i;
  assign pop_o = en && q_valid_i;

  // products of the affine map
  always_comb begin
    p11_d = 41'($signed(cfg_i.a11)) * 41'($signed({1'b0, q_entry_i.col}));
    p12_d = 41'($signed(cfg_i.a12)) * 41'($signed({1'b0, q_entry_i.row}));
    p21_d = 41'($signed(cfg_i.a21)) * 41'($signed({1'b0, q_entry_i.col}));
    p22_d = 41'($signed(cfg_i.a22)) * 41'($signed({1'b0, q_entry_i.row}));
  end

  // sums with round half up, floor taken by dropping the fraction
  always_comb begin
    sx = 43'(p11_q) + 43'(p12_q) + 43'($signed(cfg_i.a13)) + ROUND_HALF;
    sy = 43'(p21_q) + 43'(p22_q) + 43'($signed(cfg_i.a23)) + ROUND_HALF;
  end

  // bounds check and store address
  always_comb begin
    inside_d = !ix_q[26] && !iy_q[26] &&
               (ix_q[25:0] < 26'(cfg_i.src_width)) && (ix_q[25:0] < 26'(IMAGE_DIM)) &&
               (iy_q[25:0] < 26'(cfg_i.src_height)) && (iy_q[25:0] < 26'(IMAGE_DIM));
    if (s2_entry_q.is_sample) begin
      addr_d = {iy_q[AW-1:0], ix_q[AW-1:0]};
    end else begin
      addr_d = {AW'(s2_entry_q.row), AW'(s2_entry_q.col)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= q_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      out_valid_q <= s3_valid_q && s3_sample_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_entry_q <= q_entry_i;
      p11_q <= p11_d;
      p12_q <= p12_d;
      p21_q <= p21_d;
      p22_q <= p22_d;
      s2_entry_q <= s1_entry_q;
      ix_q <= sx[42:16];
      iy_q <= sy[42:16];
      s3_sample_q <= s2_entry_q.is_sample;
      s3_inside_q <= inside_d;
      s3_addr_q <= addr_d;
      s3_pix_q <= s2_entry_q.pix[MEM_W-1:0];
      out_inside_q <= s3_inside_q;
    end
  end

  // frame store, one write and one read port
  always_ff @(posedge clk_i) begin
    if (en && s3_valid_q && !s3_sample_q) begin
      mem[s3_addr_q] <= s3_pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s3_valid_q && s3_sample_q) begin
      rdata_q <= mem[s3_addr_q];
    end
  end

  assign pix_out = out_inside_q ? 24'(rdata_q) : 24'd0;
  assign out_valid_o = out_valid_q;
  assign out_data_o.out_ch0 = pix_out[7:0];
  assign out_data_o.out_ch1 = pix_out[15:8];
  assign out_data_o.out_ch2 = pix_out[23:16];
  assign out_data_o.inside_res = out_inside_q;

endmodule

/* rtl/affine_warp_nearest_sampler.sv */
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_stall_o   in_data_i  (awns_in_t)
// out      out  out_valid_o / out_stall_i out_data_o (awns_out_t)
// cfg      in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one word per cycle in and out while neither side stalls; a sample word passes through
// the queue, multiply, sum and round, bounds check and frame store read in that order
// rate is set by the frame store, one write and one read port, one access per cycle
// load words give no output; reset clears control and config, not the frame store
// a stalled output holds the back pipeline; the 4-entry queue keeps taking input until full
module affine_warp_nearest_sampler #(
  parameter int IMAGE_DIM = 256,
  parameter int CHANNELS = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  awns_pkg::awns_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output awns_pkg::awns_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [awns_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import awns_pkg::*;

  awns_cfg_t   cfg;
  logic        q_valid, pop;
  awns_entry_t q_entry;

  awns_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  awns_front #(
    .IMAGE_DIM (IMAGE_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .pop_i      (pop)
  );

  awns_back #(
    .IMAGE_DIM (IMAGE_DIM),
    .CHANNELS  (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
